// ===== src/dle_pkg.sv =====
// Shared types, codes and constants for the DLE-escaped telegram receiver.
package dle_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // Status codes reported with every response.
   localparam logic [2:0] STATUS_IDLE  = 3'd0;
   localparam logic [2:0] STATUS_RECV  = 3'd1;
   localparam logic [2:0] STATUS_CHECK = 3'd2;
   localparam logic [2:0] STATUS_DONE  = 3'd3;
   localparam logic [2:0] STATUS_ERROR = 3'd4;

   // Line control characters.
   localparam logic [7:0] CHAR_DLE = 8'h10;
   localparam logic [7:0] CHAR_ETX = 8'h03;

   // Width of the payload counter, enough for the largest telegram length.
   localparam int unsigned COUNT_WIDTH = 8;
   localparam int unsigned INDEX_WIDTH = 7;

   // Receiver phase, one-hot.
   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_RECV  = 5'b00010,
      PH_CHECK = 5'b00100,
      PH_DONE  = 5'b01000,
      PH_ERROR = 5'b10000
   } phase_type;

   // One response item as it leaves the deframer.
   typedef struct packed {
      logic [2:0]             status;
      logic [7:0]             data_byte;
      logic                   data_valid;
      logic [INDEX_WIDTH-1:0] byte_index;
   } result_type;

   // Map the one-hot phase onto the reported status code.
   function automatic logic [2:0] phase_status(input phase_type phase);
      logic [2:0] code;
      unique case (phase)
         PH_IDLE:  code = STATUS_IDLE;
         PH_RECV:  code = STATUS_RECV;
         PH_CHECK: code = STATUS_CHECK;
         PH_DONE:  code = STATUS_DONE;
         PH_ERROR: code = STATUS_ERROR;
         default:  code = STATUS_ERROR;
      endcase
      return code;
   endfunction

endpackage

// ===== src/dle_escaped_telegram_receiver.sv =====
// Top level of the DLE-escaped telegram receiver: request stage, deframer and response stage.
//
//  Channel  Direction  Payload
//  req_     in         tuser = op[1:0]; tdata = rx_byte[7:0]
//  rsp_     out        tuser = data_valid; tdata = status, data_byte, byte_index
//
// Each request moves from the request register into the response register, from which
// its response leaves. A new request is accepted every cycle unless the response stalls.
// The deframer state updates as a request moves from the request register to the
// response register. Reset is synchronous and active high and returns to idle.
// A stalled response holds both stages; a free response stage lets both move.
module dle_escaped_telegram_receiver #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [2:0] status, [10:3] data_byte, [17:11] byte_index, zeros
   output logic [0:0]  rsp_tuser    // [0] data_valid
);
   import dle_pkg::*;

   logic       req_valid_ff;
   logic [1:0] req_op_ff;
   logic [7:0] req_byte_ff;

   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;

   logic       out_free;
   logic       advance;

   // Both stages move together whenever the response register can take an item.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && out_free;
   assign req_tready = !req_valid_ff || out_free;

   // Request register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_op_ff   <= req_tuser;
         req_byte_ff <= req_tdata;
      end
   end

   dle_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .op     (req_op_ff),
      .rx_byte(req_byte_ff),
      .result (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff.byte_index, rsp_ff.data_byte, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.data_valid;

   // A response in flight is never lost: a held response blocks the request stage.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && req_valid_ff |-> !req_tready)
      else $error("request accepted over a full pipeline");

   // The response register only fills from a valid request.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(req_valid_ff))
      else $error("response appeared without a request");

   // A response without payload carries zero byte and index.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.data_valid |-> rsp_tdata[17:3] == '0)
      else $error("payload fields set without data");

endmodule

// ===== src/dle_core.sv =====
// Deframer state and per-byte decode: phase, escape flag, check character and count.
module dle_core #(
   parameter int unsigned MAX_PAYLOAD = 128
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [1:0]         op,
   input  logic [7:0]         rx_byte,
   output dle_pkg::result_type result
);
   import dle_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MaxCount = COUNT_WIDTH'(MAX_PAYLOAD);

   phase_type              phase_ff, phase_in;
   logic                   escape_ff, escape_in;
   logic [7:0]             check_ff, check_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;

   logic                   emit;

   // Next state and the response for the request that is moving through.
   always_comb begin
      phase_in  = phase_ff;
      escape_in = escape_ff;
      check_in  = check_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      unique case (op)
         OP_START: begin
            phase_in  = PH_RECV;
            escape_in = 1'b0;
            check_in  = '0;
            count_in  = '0;
         end
         OP_RESET: begin
            phase_in  = PH_IDLE;
            escape_in = 1'b0;
            check_in  = '0;
            count_in  = '0;
         end
         OP_BYTE: begin
            if (phase_ff == PH_RECV) begin
               if (count_ff >= MaxCount) begin
                  // Length overrun: the byte is dropped.
                  phase_in = PH_ERROR;
               end else begin
                  emit     = 1'b1;
                  check_in = check_ff ^ rx_byte;
                  if (rx_byte == CHAR_DLE) begin
                     // First DLE is held back; the second one is data.
                     escape_in = !escape_ff;
                     emit      = escape_ff;
                  end else if (escape_ff && rx_byte == CHAR_ETX) begin
                     escape_in = 1'b0;
                     phase_in  = PH_CHECK;
                     emit      = 1'b0;
                  end else if (escape_ff) begin
                     // DLE before anything else is a framing error.
                     phase_in = PH_ERROR;
                  end
                  if (emit) begin
                     count_in = count_ff + COUNT_WIDTH'(1);
                  end
               end
            end else if (phase_ff == PH_CHECK) begin
               phase_in = (rx_byte == check_ff) ? PH_DONE : PH_ERROR;
            end
         end
         OP_NONE: begin
            phase_in = phase_ff;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase

      result.status     = phase_status(phase_in);
      result.data_valid = emit;
      result.data_byte  = emit ? rx_byte : 8'h00;
      result.byte_index = emit ? count_ff[INDEX_WIDTH-1:0] : '0;
   end

   // State registers, updated only when a request moves into the response stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         escape_ff <= 1'b0;
         check_ff  <= '0;
         count_ff  <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         escape_ff <= escape_in;
         check_ff  <= check_in;
         count_ff  <= count_in;
      end
   end

   // The payload count never passes the telegram limit.
   assert property (@(posedge clock) disable iff (reset) count_ff <= MaxCount)
      else $error("payload count exceeds limit");

   // A payload byte is only produced while a telegram is being received.
   assert property (@(posedge clock) disable iff (reset)
      result.data_valid |-> phase_ff == PH_RECV && op == OP_BYTE)
      else $error("payload byte outside receive phase");

   // Outside a receive or check phase, bytes leave all state alone.
   assert property (@(posedge clock) disable iff (reset)
      advance && op == OP_BYTE && (phase_ff == PH_IDLE || phase_ff == PH_DONE
         || phase_ff == PH_ERROR) |=> $stable(check_ff) && $stable(count_ff)
         && $stable(phase_ff))
      else $error("ignored byte changed state");

endmodule
